/* design/cns_pkg.sv */
// shared types, constants and helper functions of the colored noise shaper
`timescale 1ns / 1ps

package cns_pkg;

  // default half scale of the unsigned output
  localparam int unsigned HALF_SCALE_DEF = 32768;

  // configuration port
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_NOISE_TYPE = 1'b0;
  localparam logic REG_GAIN       = 1'b1;
  localparam logic [15:0] GAIN_RESET = 16'd32768;

  // noise coloring codes
  localparam logic [1:0] NT_WHITE = 2'd0;
  localparam logic [1:0] NT_PINK  = 2'd1;
  localparam logic [1:0] NT_BROWN = 2'd2;

  // pink filter: six pole/zero terms plus one delayed term
  localparam int unsigned PINK_FILTERS = 6;
  localparam int unsigned PINK_TERMS   = 7;

  // q0.20 coefficients
  localparam logic signed [20:0] DIRECT_K   = 21'sd562246;
  localparam logic signed [20:0] DELAY_K    = 21'sd121557;
  localparam logic signed [20:0] BROWN_STEP = 21'sd20972;

  // shared multiplier operand selection
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_POLE,
    MUL_FEED,
    MUL_DIRECT,
    MUL_DELAY,
    MUL_BROWN,
    MUL_GAIN,
    MUL_PLO,
    MUL_PHI
  } cns_mul_e;

  // use of the product registered in the previous cycle
  typedef enum logic [3:0] {
    POST_NONE,
    POST_TLOAD,
    POST_TUPD,
    POST_DIRECT,
    POST_DELAY,
    POST_BROWN,
    POST_P1,
    POST_ALO,
    POST_AHI,
    POST_OUT
  } cns_post_e;

  // command from the sequencer to the datapath
  typedef struct packed {
    logic      start;
    cns_mul_e  mul_sel;
    logic [2:0] mul_idx;
    cns_post_e post_op;
    logic [2:0] post_idx;
  } cns_cmd_t;

  // feedback coefficient of pink term idx
  function automatic logic signed [20:0] pole_coef(input logic [2:0] idx);
    logic signed [20:0] c;
    case (idx)
      3'd0: c = 21'sd1047381;
      3'd1: c = 21'sd1041572;
      3'd2: c = 21'sd1016070;
      3'd3: c = 21'sd908591;
      3'd4: c = 21'sd576717;
      3'd5: c = -21'sd798595;
      default: c = '0;
    endcase
    return c;
  endfunction

  // feed coefficient of pink term idx
  function automatic logic signed [20:0] feed_coef(input logic [2:0] idx);
    logic signed [20:0] c;
    case (idx)
      3'd0: c = 21'sd58215;
      3'd1: c = 21'sd78723;
      3'd2: c = 21'sd161326;
      3'd3: c = 21'sd325568;
      3'd4: c = 21'sd558841;
      3'd5: c = -21'sd17719;
      default: c = '0;
    endcase
    return c;
  endfunction

  // saturate to the q3.20 range
  function automatic logic signed [23:0] sat24(input logic signed [27:0] x);
    logic signed [23:0] r;
    if (x > 28'sd8388607) begin
      r = 24'sd8388607;
    end else if (x < -28'sd8388608) begin
      r = -24'sd8388608;
    end else begin
      r = 24'(x);
    end
    return r;
  endfunction

endpackage

/* design/cns_if.sv */
// valid/ready channels for input items and result items
`timescale 1ns / 1ps

interface cns_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] white_sample;
  logic               restart;

  modport source (output valid, output white_sample, output restart, input ready);
  modport sink (input valid, input white_sample, input restart, output ready);
endinterface

interface cns_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] audio_out;

  modport source (output valid, output audio_out, input ready);
  modport sink (input valid, input audio_out, output ready);
endinterface

/* design/cns_dp.sv */
// datapath: shared multiplier, filter state, accumulators and output register
`timescale 1ns / 1ps

module cns_dp #(
  parameter int unsigned HALF_SCALE = cns_pkg::HALF_SCALE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cns_pkg::cns_cmd_t  cmd_i,
  input  logic signed [15:0] white_sample_i,
  input  logic               restart_i,
  input  logic [15:0]        gain_i,
  output logic [15:0]        audio_out_o
);
  import cns_pkg::*;

  localparam logic [22:0] Hm1    = 23'(HALF_SCALE - 1);
  localparam logic [23:0] OutMax = 24'(2 * HALF_SCALE - 1);

  logic signed [20:0] w_q;
  logic signed [23:0] terms_q [PINK_TERMS];
  logic signed [23:0] brown_q;
  logic signed [25:0] tacc_q;
  logic signed [27:0] sum_q;
  logic signed [23:0] v_q;
  logic signed [39:0] p1_q;
  logic signed [63:0] acc_q;
  logic signed [49:0] prod_q;
  logic [15:0]        audio_q;

  logic signed [24:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [49:0] rnd_full;
  logic signed [29:0] rnd;
  logic signed [27:0] t_raw;
  logic signed [23:0] t_new;
  logic signed [25:0] b_raw;
  logic signed [23:0] b_new;
  logic signed [28:0] o_shr;
  logic signed [29:0] o_raw;
  logic [15:0]        o_sat;

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul_sel)
      MUL_POLE: begin
        mul_a = 25'(pole_coef(cmd_i.mul_idx));
        mul_b = 25'(terms_q[cmd_i.mul_idx]);
      end
      MUL_FEED: begin
        mul_a = 25'(w_q);
        mul_b = 25'(feed_coef(cmd_i.mul_idx));
      end
      MUL_DIRECT: begin
        mul_a = 25'(w_q);
        mul_b = 25'(DIRECT_K);
      end
      MUL_DELAY: begin
        mul_a = 25'(w_q);
        mul_b = 25'(DELAY_K);
      end
      MUL_BROWN: begin
        mul_a = 25'(w_q);
        mul_b = 25'(BROWN_STEP);
      end
      MUL_GAIN: begin
        mul_a = 25'(v_q);
        mul_b = $signed({9'd0, gain_i});
      end
      MUL_PLO: begin
        mul_a = $signed({5'd0, p1_q[19:0]});
        mul_b = $signed({2'd0, Hm1});
      end
      MUL_PHI: begin
        mul_a = 25'($signed(p1_q[39:20]));
        mul_b = $signed({2'd0, Hm1});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // rounded q0.20 product, term update, brown clamp and output saturation
  always_comb begin
    rnd_full = prod_q + 50'sd524288;
    rnd      = $signed(rnd_full[49:20]);
    t_raw    = 28'(tacc_q) + 28'(rnd);
    t_new    = sat24(t_raw);
    b_raw    = 26'(brown_q) + 26'(rnd);
    if (b_raw > 26'sd1048576) begin
      b_new = 24'sd1048576;
    end else if (b_raw < -26'sd1048576) begin
      b_new = -24'sd1048576;
    end else begin
      b_new = 24'(b_raw);
    end
    o_shr = $signed(acc_q[63:35]);
    o_raw = 30'(o_shr) + $signed({7'd0, Hm1});
    if (o_raw < 30'sd0) begin
      o_sat = '0;
    end else if (o_raw > $signed({6'd0, OutMax})) begin
      o_sat = OutMax[15:0];
    end else begin
      o_sat = o_raw[15:0];
    end
  end

  // filter state, cleared by reset and by a restart item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PINK_TERMS; k++) begin
        terms_q[k] <= '0;
      end
      brown_q <= '0;
    end else if (cmd_i.start) begin
      if (restart_i) begin
        for (int k = 0; k < PINK_TERMS; k++) begin
          terms_q[k] <= '0;
        end
        brown_q <= '0;
      end
    end else begin
      case (cmd_i.post_op)
        POST_TUPD:  terms_q[cmd_i.post_idx] <= t_new;
        POST_DELAY: terms_q[PINK_TERMS-1] <= sat24(28'(rnd));
        POST_BROWN: brown_q <= b_new;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (cmd_i.start) begin
      w_q   <= {white_sample_i, 5'd0};
      v_q   <= 24'($signed({white_sample_i, 5'd0}));
      sum_q <= restart_i ? '0 : 28'(terms_q[PINK_TERMS-1]);
    end else begin
      case (cmd_i.post_op)
        POST_TLOAD:  tacc_q <= 26'(rnd);
        POST_TUPD:   sum_q <= sum_q + 28'(t_new);
        POST_DIRECT: sum_q <= sum_q + 28'(rnd);
        POST_DELAY:  v_q <= sat24(sum_q);
        POST_BROWN:  v_q <= b_new;
        POST_P1:     p1_q <= prod_q[39:0];
        POST_ALO:    acc_q <= 64'(prod_q);
        POST_AHI:    acc_q <= acc_q + (64'(prod_q) <<< 20);
        POST_OUT:    audio_q <= o_sat;
        default: ;
      endcase
    end
  end

  assign audio_out_o = audio_q;

endmodule

/* design/cns_ctrl.sv */
// sequencer: steps the shared multiplier through one item and drives the handshakes
`timescale 1ns / 1ps

module cns_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic [1:0]        noise_type_i,
  output cns_pkg::cns_cmd_t cmd_o
);
  import cns_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PINK  = 2'd1;
  localparam logic [1:0] ST_BROWN = 2'd2;
  localparam logic [1:0] ST_SCALE = 2'd3;

  localparam logic [3:0] PINK_DIRECT = 4'd12;
  localparam logic [3:0] PINK_DELAY  = 4'd13;

  localparam logic [3:0] SC_GAIN = 4'd0;
  localparam logic [3:0] SC_P1   = 4'd1;
  localparam logic [3:0] SC_PLO  = 4'd2;
  localparam logic [3:0] SC_PHI  = 4'd3;
  localparam logic [3:0] SC_AHI  = 4'd4;

  localparam logic [2:0] LastFilter = 3'(PINK_FILTERS - 1);

  logic [1:0] state_q, state_d;
  logic [3:0] step_q, step_d;
  logic       out_valid_q, out_valid_d;

  // step schedule
  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.mul_sel  = MUL_NONE;
    cmd_o.post_op  = POST_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          step_d      = '0;
          case (noise_type_i)
            NT_PINK:  state_d = ST_PINK;
            NT_BROWN: state_d = ST_BROWN;
            default:  state_d = ST_SCALE;
          endcase
        end
      end
      ST_PINK: begin
        step_d = step_q + 4'd1;
        if (step_q < PINK_DIRECT) begin
          cmd_o.mul_idx = step_q[3:1];
          if (!step_q[0]) begin
            cmd_o.mul_sel = MUL_POLE;
            if (step_q != '0) begin
              cmd_o.post_op  = POST_TUPD;
              cmd_o.post_idx = step_q[3:1] - 3'd1;
            end
          end else begin
            cmd_o.mul_sel = MUL_FEED;
            cmd_o.post_op = POST_TLOAD;
          end
        end else if (step_q == PINK_DIRECT) begin
          cmd_o.mul_sel  = MUL_DIRECT;
          cmd_o.post_op  = POST_TUPD;
          cmd_o.post_idx = LastFilter;
        end else if (step_q == PINK_DELAY) begin
          cmd_o.mul_sel = MUL_DELAY;
          cmd_o.post_op = POST_DIRECT;
        end else begin
          cmd_o.post_op = POST_DELAY;
          state_d       = ST_SCALE;
          step_d        = '0;
        end
      end
      ST_BROWN: begin
        if (step_q == '0) begin
          cmd_o.mul_sel = MUL_BROWN;
          step_d        = 4'd1;
        end else begin
          cmd_o.post_op = POST_BROWN;
          state_d       = ST_SCALE;
          step_d        = '0;
        end
      end
      ST_SCALE: begin
        step_d = step_q + 4'd1;
        case (step_q)
          SC_GAIN: cmd_o.mul_sel = MUL_GAIN;
          SC_P1:   cmd_o.post_op = POST_P1;
          SC_PLO:  cmd_o.mul_sel = MUL_PLO;
          SC_PHI: begin
            cmd_o.mul_sel = MUL_PHI;
            cmd_o.post_op = POST_ALO;
          end
          SC_AHI:  cmd_o.post_op = POST_AHI;
          default: begin
            // wait until the output register is free
            step_d = step_q;
            if (!out_valid_q || out_ready_i) begin
              cmd_o.post_op = POST_OUT;
              state_d       = ST_IDLE;
            end
          end
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output item valid
  always_comb begin
    if (cmd_o.post_op == POST_OUT) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* design/colored_noise_shaper_core.sv */
// top level: configuration registers, sequencer and datapath of the noise shaper
`timescale 1ns / 1ps

// Each input item carries one Q1.15 white sample and gives one unsigned audio
// sample, colored white, pink or brown by the noise_type register, scaled by
// gain and offset to HALF_SCALE - 1. One 25x25 multiplier, registered at its
// output, is shared by all filter products and the gain scaling, so an item
// occupies the block until all of its products are done, longest in pink mode
// and shortest in white mode, before the next item can be taken. The result
// sits in an output register, so a new item is accepted while the previous
// result waits for the sink. An item with restart set clears the pink and
// brown state before it is filtered.

module colored_noise_shaper_core #(
  parameter int unsigned HALF_SCALE = cns_pkg::HALF_SCALE_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  cns_in_if.sink                     item_in_i,
  cns_out_if.source                  item_out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cns_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import cns_pkg::*;

  logic [1:0]  noise_type_q;
  logic [15:0] gain_q;
  logic        cfg_wr;
  cns_cmd_t    cmd;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_type_q <= NT_WHITE;
      gain_q       <= GAIN_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[ADDR_W-1])
        REG_NOISE_TYPE: noise_type_q <= pwdata[1:0];
        REG_GAIN:       gain_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[ADDR_W-1])
      REG_NOISE_TYPE: prdata = {30'd0, noise_type_q};
      REG_GAIN:       prdata = {16'd0, gain_q};
      default:        prdata = '0;
    endcase
  end

  cns_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (item_in_i.valid),
    .in_ready_o   (item_in_i.ready),
    .out_valid_o  (item_out_o.valid),
    .out_ready_i  (item_out_o.ready),
    .noise_type_i (noise_type_q),
    .cmd_o        (cmd)
  );

  cns_dp #(
    .HALF_SCALE (HALF_SCALE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .white_sample_i (item_in_i.white_sample),
    .restart_i      (item_in_i.restart),
    .gain_i         (gain_q),
    .audio_out_o    (item_out_o.audio_out)
  );

  // an accepted item keeps the sequencer busy in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_in_i.valid && item_in_i.ready |=> !item_in_i.ready)
    else $error("input accepted on consecutive cycles");

  // the datapath only latches a new item when one is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> item_in_i.valid && item_in_i.ready)
    else $error("item start without input handshake");

  // a result never overwrites one that the sink has not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.post_op == POST_OUT |-> !item_out_o.valid || item_out_o.ready)
    else $error("result register overwritten");

  // no result appears in the cycle right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_in_i.valid && item_in_i.ready |=> !$rose(item_out_o.valid))
    else $error("result too early after accept");

endmodule
